// File: rtl/icrmc_pkg.sv
// ----------------------------------------------------------------------------
// icrmc_pkg
// shared types and constants for the ipv4 checksum repair / mss clamp block
// ----------------------------------------------------------------------------
`default_nettype none

package icrmc_pkg;

    localparam int FRAME_BYTES_DEF = 2048;

    // frame byte offsets
    localparam int OFF_ETYPE_HI = 12;
    localparam int OFF_ETYPE_LO = 13;
    localparam int OFF_IP       = 14;
    localparam int OFF_VIHL     = 14;
    localparam int OFF_TOT_HI   = 16;
    localparam int OFF_TOT_LO   = 17;
    localparam int OFF_FRAG_HI  = 20;
    localparam int OFF_FRAG_LO  = 21;
    localparam int OFF_PROTO    = 23;
    localparam int OFF_HCK_HI   = 24;
    localparam int OFF_PSEUDO   = 26;
    localparam int PSEUDO_END   = 34;
    localparam int MIN_FRAME    = 34;

    // l4 offsets
    localparam int L4_ICMP_CK   = 2;
    localparam int L4_TCP_OFF   = 12;
    localparam int L4_TCP_FLAGS = 13;
    localparam int L4_TCP_CK    = 16;
    localparam int TCP_OPT_BASE = 20;

    localparam logic [7:0] ETYPE_HI_IPV4 = 8'h08;
    localparam logic [7:0] ETYPE_LO_IPV4 = 8'h00;
    localparam logic [3:0] IP_VERSION    = 4'd4;
    localparam logic [7:0] FRAG_MASK     = 8'h3F;
    localparam logic [7:0] TCP_SYN       = 8'h02;
    localparam logic [7:0] PROTO_ICMP    = 8'd1;
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] OPT_END       = 8'd0;
    localparam logic [7:0] OPT_NOP       = 8'd1;
    localparam logic [7:0] OPT_MSS       = 8'd2;
    localparam logic [7:0] OPT_MSS_LEN   = 8'd4;

    typedef enum logic [1:0] {
        TP_IDLE,
        TP_FETCH,
        TP_REPAIR
    } top_state_t;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_RD,
        SQ_CAP,
        SQ_SUM,
        SQ_ADD_P,
        SQ_ADD_L,
        SQ_FOLD,
        SQ_WR_HI,
        SQ_WR_LO,
        SQ_DONE
    } seq_state_t;

    typedef enum logic [4:0] {
        ST_ET0, ST_ET1, ST_VIHL, ST_TOT0, ST_TOT1,
        ST_HCK0, ST_HCK1, ST_FRAG0, ST_FRAG1, ST_PROTO,
        ST_ICK0, ST_ICK1, ST_TFLAG, ST_TOFF, ST_OPT,
        ST_OLEN, ST_MSS0, ST_MSS1, ST_TCK0, ST_TCK1
    } step_t;

    typedef enum logic [1:0] {
        SUM_HDR,
        SUM_ICMP,
        SUM_PSEUDO,
        SUM_TCP
    } sum_t;

    typedef enum logic [1:0] {
        POST_DONE,
        POST_FRAG,
        POST_ZERO,
        POST_TCK
    } post_t;

    typedef struct packed {
        logic        clr;
        logic        add;
        logic        fold;
        logic [15:0] val;
    } csum_ctrl_t;

    typedef struct packed {
        logic done;
        logic hdr_fix;
        logic icmp_fix;
        logic tcp_fix;
        logic mss_low;
    } seq_stat_t;

endpackage

`default_nettype wire

// File: rtl/icrmc_ram.sv
// ----------------------------------------------------------------------------
// icrmc_ram
// single port ram, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module icrmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = icrmc_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: rtl/icrmc_csum.sv
// ----------------------------------------------------------------------------
// icrmc_csum
// ones complement accumulator with iterative carry fold
// ----------------------------------------------------------------------------
`default_nettype none

module icrmc_csum #(
    parameter int FRAME_BYTES = icrmc_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                   aclk,
    input  wire icrmc_pkg::csum_ctrl_t  ctrl,
    output logic                        fold_done,
    output logic [15:0]                 cks
);

    localparam int SUM_W = 16 + $clog2(FRAME_BYTES);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    always_comb begin
        priority if (ctrl.clr) begin
            sum_next = '0;
        end else if (ctrl.add) begin
            sum_next = sum_reg + SUM_W'(ctrl.val);
        end else if (ctrl.fold) begin
            sum_next = SUM_W'(sum_reg[15:0]) + SUM_W'(sum_reg[SUM_W-1:16]);
        end else begin
            sum_next = sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign fold_done = (sum_reg[SUM_W-1:16] == '0);
    assign cks       = ~sum_reg[15:0];

endmodule

`default_nettype wire

// File: rtl/icrmc_seq.sv
// ----------------------------------------------------------------------------
// icrmc_seq
// repair sequencer: parses headers, clamps mss and rewrites checksums in the
// frame buffer through one read/write port
// ----------------------------------------------------------------------------
`default_nettype none

module icrmc_seq #(
    parameter int FRAME_BYTES = icrmc_pkg::FRAME_BYTES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [$clog2(FRAME_BYTES+1)-1:0] frame_len,
    input  wire logic [15:0]                      mss_clamp,
    output logic                                  ram_we,
    output logic [$clog2(FRAME_BYTES)-1:0]        ram_addr,
    output logic [7:0]                            ram_wdata,
    input  wire logic [7:0]                       ram_rdata,
    output icrmc_pkg::seq_stat_t                  stat
);

    localparam int POS_W  = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W = $clog2(FRAME_BYTES);

    icrmc_pkg::seq_state_t state_reg, state_next;
    icrmc_pkg::step_t      step_reg, step_next;
    icrmc_pkg::sum_t       kind_reg, kind_next;
    icrmc_pkg::post_t      post_reg, post_next;
    icrmc_pkg::csum_ctrl_t csum_ctrl;

    logic [POS_W-1:0] addr_reg, addr_next;
    logic [7:0]       hold_reg, hold_next;
    logic [7:0]       vihl_reg, vihl_next;
    logic [7:0]       proto_reg, proto_next;
    logic [7:0]       opt_reg, opt_next;
    logic [15:0]      l4len_reg, l4len_next;
    logic [POS_W-1:0] l4_reg, l4_next;
    logic [5:0]       thdr_reg, thdr_next;
    logic [8:0]       at_reg, at_next;
    logic [POS_W-1:0] ptr_reg, ptr_next;
    logic [POS_W-1:0] end_reg, end_next;
    logic             pend_reg, pend_next;
    logic             pend_hi_reg, pend_hi_next;
    logic [POS_W-1:0] wr_addr_reg, wr_addr_next;
    logic [15:0]      wr_val_reg, wr_val_next;
    logic             hdr_fix_reg, hdr_fix_next;
    logic             icmp_fix_reg, icmp_fix_next;
    logic             tcp_fix_reg, tcp_fix_next;
    logic             mss_low_reg, mss_low_next;

    logic             fold_done;
    logic [15:0]      cks;

    logic             rd_go;
    icrmc_pkg::step_t rd_step;
    logic [POS_W-1:0] rd_pos;
    logic             fin;
    logic [5:0]       ihl;
    logic [15:0]      tot;
    logic [15:0]      pair;
    logic [8:0]       at_nop;
    logic [8:0]       at_skip;
    logic [5:0]       thdr_cap;

    icrmc_csum #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_csum (
        .aclk      (aclk),
        .ctrl      (csum_ctrl),
        .fold_done (fold_done),
        .cks       (cks)
    );

    assign ihl      = {vihl_reg[3:0], 2'b00};
    assign pair     = {hold_reg, ram_rdata};
    assign tot      = pair;
    assign at_nop   = at_reg + 9'd1;
    assign at_skip  = at_reg + 9'(ram_rdata);
    assign thdr_cap = {ram_rdata[7:4], 2'b00};

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        kind_next     = kind_reg;
        post_next     = post_reg;
        addr_next     = addr_reg;
        hold_next     = hold_reg;
        vihl_next     = vihl_reg;
        proto_next    = proto_reg;
        opt_next      = opt_reg;
        l4len_next    = l4len_reg;
        l4_next       = l4_reg;
        thdr_next     = thdr_reg;
        at_next       = at_reg;
        ptr_next      = ptr_reg;
        end_next      = end_reg;
        pend_next     = 1'b0;
        pend_hi_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        wr_val_next   = wr_val_reg;
        hdr_fix_next  = hdr_fix_reg;
        icmp_fix_next = icmp_fix_reg;
        tcp_fix_next  = tcp_fix_reg;
        mss_low_next  = mss_low_reg;
        rd_go         = 1'b0;
        rd_step       = step_reg;
        rd_pos        = addr_reg;
        fin           = 1'b0;

        unique case (state_reg)
            icrmc_pkg::SQ_IDLE: begin
                if (start) begin
                    hdr_fix_next  = 1'b0;
                    icmp_fix_next = 1'b0;
                    tcp_fix_next  = 1'b0;
                    mss_low_next  = 1'b0;
                    rd_go   = 1'b1;
                    rd_step = icrmc_pkg::ST_ET0;
                    rd_pos  = POS_W'(icrmc_pkg::OFF_ETYPE_HI);
                end
            end
            icrmc_pkg::SQ_RD: begin
                state_next = icrmc_pkg::SQ_CAP;
            end
            icrmc_pkg::SQ_CAP: begin
                hold_next = ram_rdata;
                unique case (step_reg)
                    icrmc_pkg::ST_ET0: begin
                        if (frame_len < POS_W'(icrmc_pkg::MIN_FRAME) ||
                            ram_rdata != icrmc_pkg::ETYPE_HI_IPV4) begin
                            fin = 1'b1;
                        end else begin
                            rd_go   = 1'b1;
                            rd_step = icrmc_pkg::ST_ET1;
                            rd_pos  = POS_W'(icrmc_pkg::OFF_ETYPE_LO);
                        end
                    end
                    icrmc_pkg::ST_ET1: begin
                        if (ram_rdata != icrmc_pkg::ETYPE_LO_IPV4) begin
                            fin = 1'b1;
                        end else begin
                            rd_go   = 1'b1;
                            rd_step = icrmc_pkg::ST_VIHL;
                            rd_pos  = POS_W'(icrmc_pkg::OFF_VIHL);
                        end
                    end
                    icrmc_pkg::ST_VIHL: begin
                        vihl_next = ram_rdata;
                        rd_go   = 1'b1;
                        rd_step = icrmc_pkg::ST_TOT0;
                        rd_pos  = POS_W'(icrmc_pkg::OFF_TOT_HI);
                    end
                    icrmc_pkg::ST_TOT0: begin
                        rd_go   = 1'b1;
                        rd_step = icrmc_pkg::ST_TOT1;
                        rd_pos  = POS_W'(icrmc_pkg::OFF_TOT_LO);
                    end
                    icrmc_pkg::ST_TOT1: begin
                        if (vihl_reg[7:4] != icrmc_pkg::IP_VERSION || ihl < 6'd20 ||
                            tot < 16'(ihl) ||
                            (17'(tot) + 17'd14) > 17'(frame_len)) begin
                            fin = 1'b1;
                        end else begin
                            l4_next    = POS_W'(icrmc_pkg::OFF_IP) + POS_W'(ihl);
                            l4len_next = tot - 16'(ihl);
                            rd_go   = 1'b1;
                            rd_step = icrmc_pkg::ST_HCK0;
                            rd_pos  = POS_W'(icrmc_pkg::OFF_HCK_HI);
                        end
                    end
                    icrmc_pkg::ST_HCK0: begin
                        rd_go   = 1'b1;
                        rd_step = icrmc_pkg::ST_HCK1;
                        rd_pos  = POS_W'(icrmc_pkg::OFF_HCK_HI + 1);
                    end
                    icrmc_pkg::ST_HCK1: begin
                        if (pair == 16'd0) begin
                            kind_next  = icrmc_pkg::SUM_HDR;
                            ptr_next   = POS_W'(icrmc_pkg::OFF_IP);
                            end_next   = POS_W'(icrmc_pkg::OFF_IP) + POS_W'(ihl);
                            state_next = icrmc_pkg::SQ_SUM;
                        end else begin
                            rd_go   = 1'b1;
                            rd_step = icrmc_pkg::ST_FRAG0;
                            rd_pos  = POS_W'(icrmc_pkg::OFF_FRAG_HI);
                        end
                    end
                    icrmc_pkg::ST_FRAG0: begin
                        if ((ram_rdata & icrmc_pkg::FRAG_MASK) != 8'd0) begin
                            fin = 1'b1;
                        end else begin
                            rd_go   = 1'b1;
                            rd_step = icrmc_pkg::ST_FRAG1;
                            rd_pos  = POS_W'(icrmc_pkg::OFF_FRAG_LO);
                        end
                    end
                    icrmc_pkg::ST_FRAG1: begin
                        if (ram_rdata != 8'd0) begin
                            fin = 1'b1;
                        end else begin
                            rd_go   = 1'b1;
                            rd_step = icrmc_pkg::ST_PROTO;
                            rd_pos  = POS_W'(icrmc_pkg::OFF_PROTO);
                        end
                    end
                    icrmc_pkg::ST_PROTO: begin
                        proto_next = ram_rdata;
                        priority if (ram_rdata == icrmc_pkg::PROTO_ICMP &&
                                     l4len_reg >= 16'd8) begin
                            rd_go   = 1'b1;
                            rd_step = icrmc_pkg::ST_ICK0;
                            rd_pos  = l4_reg + POS_W'(icrmc_pkg::L4_ICMP_CK);
                        end else if (ram_rdata == icrmc_pkg::PROTO_TCP &&
                                     l4len_reg >= 16'd20) begin
                            rd_go = 1'b1;
                            if (mss_clamp != 16'd0) begin
                                rd_step = icrmc_pkg::ST_TFLAG;
                                rd_pos  = l4_reg + POS_W'(icrmc_pkg::L4_TCP_FLAGS);
                            end else begin
                                rd_step = icrmc_pkg::ST_TCK0;
                                rd_pos  = l4_reg + POS_W'(icrmc_pkg::L4_TCP_CK);
                            end
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    icrmc_pkg::ST_ICK0: begin
                        rd_go   = 1'b1;
                        rd_step = icrmc_pkg::ST_ICK1;
                        rd_pos  = l4_reg + POS_W'(icrmc_pkg::L4_ICMP_CK + 1);
                    end
                    icrmc_pkg::ST_ICK1: begin
                        if (pair == 16'd0) begin
                            kind_next  = icrmc_pkg::SUM_ICMP;
                            ptr_next   = l4_reg;
                            end_next   = l4_reg + POS_W'(l4len_reg);
                            state_next = icrmc_pkg::SQ_SUM;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    icrmc_pkg::ST_TFLAG: begin
                        rd_go = 1'b1;
                        if ((ram_rdata & icrmc_pkg::TCP_SYN) != 8'd0) begin
                            rd_step = icrmc_pkg::ST_TOFF;
                            rd_pos  = l4_reg + POS_W'(icrmc_pkg::L4_TCP_OFF);
                        end else begin
                            rd_step = icrmc_pkg::ST_TCK0;
                            rd_pos  = l4_reg + POS_W'(icrmc_pkg::L4_TCP_CK);
                        end
                    end
                    icrmc_pkg::ST_TOFF: begin
                        thdr_next = thdr_cap;
                        at_next   = 9'(icrmc_pkg::TCP_OPT_BASE);
                        rd_go     = 1'b1;
                        if (thdr_cap >= 6'd24 && 16'(thdr_cap) <= l4len_reg) begin
                            rd_step = icrmc_pkg::ST_OPT;
                            rd_pos  = l4_reg + POS_W'(icrmc_pkg::TCP_OPT_BASE);
                        end else begin
                            rd_step = icrmc_pkg::ST_TCK0;
                            rd_pos  = l4_reg + POS_W'(icrmc_pkg::L4_TCP_CK);
                        end
                    end
                    icrmc_pkg::ST_OPT: begin
                        opt_next = ram_rdata;
                        rd_go    = 1'b1;
                        rd_step  = icrmc_pkg::ST_TCK0;
                        rd_pos   = l4_reg + POS_W'(icrmc_pkg::L4_TCP_CK);
                        priority if (ram_rdata == icrmc_pkg::OPT_END) begin
                            rd_step = icrmc_pkg::ST_TCK0;
                        end else if (ram_rdata == icrmc_pkg::OPT_NOP) begin
                            at_next = at_nop;
                            if (at_nop + 9'd1 < 9'(thdr_reg)) begin
                                rd_step = icrmc_pkg::ST_OPT;
                                rd_pos  = l4_reg + POS_W'(at_nop);
                            end
                        end else begin
                            rd_step = icrmc_pkg::ST_OLEN;
                            rd_pos  = l4_reg + POS_W'(at_reg) + POS_W'(1);
                        end
                    end
                    icrmc_pkg::ST_OLEN: begin
                        rd_go   = 1'b1;
                        rd_step = icrmc_pkg::ST_TCK0;
                        rd_pos  = l4_reg + POS_W'(icrmc_pkg::L4_TCP_CK);
                        priority if (ram_rdata < 8'd2 ||
                                     (10'(at_reg) + 10'(ram_rdata)) > 10'(thdr_reg)) begin
                            rd_step = icrmc_pkg::ST_TCK0;
                        end else if (opt_reg == icrmc_pkg::OPT_MSS &&
                                     ram_rdata == icrmc_pkg::OPT_MSS_LEN) begin
                            rd_step = icrmc_pkg::ST_MSS0;
                            rd_pos  = l4_reg + POS_W'(at_reg) + POS_W'(2);
                        end else begin
                            at_next = at_skip;
                            if (at_skip + 9'd1 < 9'(thdr_reg)) begin
                                rd_step = icrmc_pkg::ST_OPT;
                                rd_pos  = l4_reg + POS_W'(at_skip);
                            end
                        end
                    end
                    icrmc_pkg::ST_MSS0: begin
                        rd_go   = 1'b1;
                        rd_step = icrmc_pkg::ST_MSS1;
                        rd_pos  = l4_reg + POS_W'(at_reg) + POS_W'(3);
                    end
                    icrmc_pkg::ST_MSS1: begin
                        if (pair > mss_clamp) begin
                            mss_low_next = 1'b1;
                            wr_addr_next = l4_reg + POS_W'(at_reg) + POS_W'(2);
                            wr_val_next  = mss_clamp;
                            post_next    = icrmc_pkg::POST_ZERO;
                            state_next   = icrmc_pkg::SQ_WR_HI;
                        end else begin
                            rd_go   = 1'b1;
                            rd_step = icrmc_pkg::ST_TCK0;
                            rd_pos  = l4_reg + POS_W'(icrmc_pkg::L4_TCP_CK);
                        end
                    end
                    icrmc_pkg::ST_TCK0: begin
                        rd_go   = 1'b1;
                        rd_step = icrmc_pkg::ST_TCK1;
                        rd_pos  = l4_reg + POS_W'(icrmc_pkg::L4_TCP_CK + 1);
                    end
                    icrmc_pkg::ST_TCK1: begin
                        if (pair == 16'd0) begin
                            kind_next  = icrmc_pkg::SUM_PSEUDO;
                            ptr_next   = POS_W'(icrmc_pkg::OFF_PSEUDO);
                            end_next   = POS_W'(icrmc_pkg::PSEUDO_END);
                            state_next = icrmc_pkg::SQ_SUM;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            icrmc_pkg::SQ_SUM: begin
                if (ptr_reg < end_reg) begin
                    ptr_next     = ptr_reg + POS_W'(1);
                    pend_next    = 1'b1;
                    pend_hi_next = ~ptr_reg[0];
                end else if (!pend_reg) begin
                    if (kind_reg == icrmc_pkg::SUM_PSEUDO) begin
                        state_next = icrmc_pkg::SQ_ADD_P;
                    end else begin
                        state_next = icrmc_pkg::SQ_FOLD;
                    end
                end
            end
            icrmc_pkg::SQ_ADD_P: begin
                state_next = icrmc_pkg::SQ_ADD_L;
            end
            icrmc_pkg::SQ_ADD_L: begin
                kind_next  = icrmc_pkg::SUM_TCP;
                ptr_next   = l4_reg;
                end_next   = l4_reg + POS_W'(l4len_reg);
                state_next = icrmc_pkg::SQ_SUM;
            end
            icrmc_pkg::SQ_FOLD: begin
                if (fold_done) begin
                    wr_val_next = cks;
                    state_next  = icrmc_pkg::SQ_WR_HI;
                    unique case (kind_reg)
                        icrmc_pkg::SUM_HDR: begin
                            hdr_fix_next = 1'b1;
                            wr_addr_next = POS_W'(icrmc_pkg::OFF_HCK_HI);
                            post_next    = icrmc_pkg::POST_FRAG;
                        end
                        icrmc_pkg::SUM_ICMP: begin
                            icmp_fix_next = 1'b1;
                            wr_addr_next  = l4_reg + POS_W'(icrmc_pkg::L4_ICMP_CK);
                            post_next     = icrmc_pkg::POST_DONE;
                        end
                        default: begin
                            tcp_fix_next = 1'b1;
                            wr_addr_next = l4_reg + POS_W'(icrmc_pkg::L4_TCP_CK);
                            post_next    = icrmc_pkg::POST_DONE;
                        end
                    endcase
                end
            end
            icrmc_pkg::SQ_WR_HI: begin
                state_next = icrmc_pkg::SQ_WR_LO;
            end
            icrmc_pkg::SQ_WR_LO: begin
                unique case (post_reg)
                    icrmc_pkg::POST_DONE: begin
                        fin = 1'b1;
                    end
                    icrmc_pkg::POST_FRAG: begin
                        rd_go   = 1'b1;
                        rd_step = icrmc_pkg::ST_FRAG0;
                        rd_pos  = POS_W'(icrmc_pkg::OFF_FRAG_HI);
                    end
                    icrmc_pkg::POST_ZERO: begin
                        wr_addr_next = l4_reg + POS_W'(icrmc_pkg::L4_TCP_CK);
                        wr_val_next  = 16'd0;
                        post_next    = icrmc_pkg::POST_TCK;
                        state_next   = icrmc_pkg::SQ_WR_HI;
                    end
                    default: begin
                        rd_go   = 1'b1;
                        rd_step = icrmc_pkg::ST_TCK0;
                        rd_pos  = l4_reg + POS_W'(icrmc_pkg::L4_TCP_CK);
                    end
                endcase
            end
            icrmc_pkg::SQ_DONE: begin
                state_next = icrmc_pkg::SQ_IDLE;
            end
            default: begin
                state_next = icrmc_pkg::SQ_IDLE;
            end
        endcase

        if (rd_go) begin
            state_next = icrmc_pkg::SQ_RD;
            step_next  = rd_step;
            addr_next  = rd_pos;
        end
        if (fin) begin
            state_next = icrmc_pkg::SQ_DONE;
        end
    end

    always_comb begin
        ram_we         = 1'b0;
        ram_addr       = ADDR_W'(addr_reg);
        ram_wdata      = wr_val_reg[15:8];
        csum_ctrl      = '0;
        csum_ctrl.clr  = (state_reg == icrmc_pkg::SQ_RD);
        csum_ctrl.fold = (state_reg == icrmc_pkg::SQ_FOLD) && !fold_done;
        unique case (state_reg)
            icrmc_pkg::SQ_SUM: begin
                ram_addr      = ADDR_W'(ptr_reg);
                csum_ctrl.add = pend_reg;
                csum_ctrl.val = pend_hi_reg ? {ram_rdata, 8'h00} : {8'h00, ram_rdata};
            end
            icrmc_pkg::SQ_ADD_P: begin
                csum_ctrl.add = 1'b1;
                csum_ctrl.val = {8'h00, proto_reg};
            end
            icrmc_pkg::SQ_ADD_L: begin
                csum_ctrl.add = 1'b1;
                csum_ctrl.val = l4len_reg;
            end
            icrmc_pkg::SQ_WR_HI: begin
                ram_we   = 1'b1;
                ram_addr = ADDR_W'(wr_addr_reg);
            end
            icrmc_pkg::SQ_WR_LO: begin
                ram_we    = 1'b1;
                ram_addr  = ADDR_W'(wr_addr_reg + POS_W'(1));
                ram_wdata = wr_val_reg[7:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        stat.done     = (state_reg == icrmc_pkg::SQ_DONE);
        stat.hdr_fix  = hdr_fix_reg;
        stat.icmp_fix = icmp_fix_reg;
        stat.tcp_fix  = tcp_fix_reg;
        stat.mss_low  = mss_low_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= icrmc_pkg::SQ_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
        step_reg     <= step_next;
        kind_reg     <= kind_next;
        post_reg     <= post_next;
        addr_reg     <= addr_next;
        hold_reg     <= hold_next;
        vihl_reg     <= vihl_next;
        proto_reg    <= proto_next;
        opt_reg      <= opt_next;
        l4len_reg    <= l4len_next;
        l4_reg       <= l4_next;
        thdr_reg     <= thdr_next;
        at_reg       <= at_next;
        ptr_reg      <= ptr_next;
        end_reg      <= end_next;
        pend_hi_reg  <= pend_hi_next;
        wr_addr_reg  <= wr_addr_next;
        wr_val_reg   <= wr_val_next;
        hdr_fix_reg  <= hdr_fix_next;
        icmp_fix_reg <= icmp_fix_next;
        tcp_fix_reg  <= tcp_fix_next;
        mss_low_reg  <= mss_low_next;
    end

endmodule

`default_nettype wire

// File: rtl/ipv4_checksum_repair_mss_clamp.sv
// ----------------------------------------------------------------------------
// ipv4_checksum_repair_mss_clamp
// frame buffer with in-place ipv4 / icmp / tcp checksum repair and mss clamp
// ----------------------------------------------------------------------------
// The slave channel carries load beats (tuser 0: tdata byte, tlast closes the
// frame) and fetch beats (tuser 1). Loads are taken one per cycle while the
// block is idle and give no result except the closing beat, which gives one
// status beat (tuser 0). Each fetch gives one byte beat (tuser 1), read from
// the frame ram into the output register; no beat is taken while a fetch is
// in progress. Closing a frame starts the repair sequencer on the single frame
// ram port: it examines header bytes, sums the bytes of each regenerated
// checksum and then folds the carries. A frame beyond the buffer is flagged
// and reported at once without repair.
// Reset empties the frame and clears the clamp to zero (clamping off).
// When the master side stalls, the result stays in the output register;
// load beats that close nothing are still taken, other beats wait.
// The clamp register is written whenever cfg_wr_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_checksum_repair_mss_clamp #(
    parameter int FRAME_BYTES = icrmc_pkg::FRAME_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // data_in
    input  wire logic        s_axis_tuser,  // operation
    input  wire logic        s_axis_tlast,  // last_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // data_out, header_fixed, icmp_fixed,
                                            // tcp_fixed, mss_lowered, overflow
    output logic             m_axis_tuser,  // kind
    output logic             m_axis_tlast   // last_out
);

    localparam int POS_W  = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W = $clog2(FRAME_BYTES);

    icrmc_pkg::top_state_t state_reg, state_next;
    icrmc_pkg::seq_stat_t  seq_stat;

    logic [15:0]      clamp_reg;
    logic [POS_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             too_long_reg, too_long_next;
    logic             closed_reg, closed_next;
    logic             fhit_reg, fhit_next;
    logic             flast_reg, flast_next;

    logic             mv_reg, mv_next;
    logic [15:0]      md_reg, md_next;
    logic             mu_reg, mu_next;
    logic             ml_reg, ml_next;

    logic              accept;
    logic              out_free;
    logic [POS_W-1:0]  eff_len;
    logic              seq_start;
    logic              top_we;
    logic [ADDR_W-1:0] top_addr;
    logic              seq_we;
    logic [ADDR_W-1:0] seq_addr;
    logic [7:0]        seq_wdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    assign out_free      = !mv_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == icrmc_pkg::TP_IDLE) &&
                           (out_free || (!s_axis_tuser && !s_axis_tlast));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign eff_len       = closed_reg ? '0 : len_reg;

    icrmc_seq #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (seq_start),
        .frame_len (len_reg),
        .mss_clamp (clamp_reg),
        .ram_we    (seq_we),
        .ram_addr  (seq_addr),
        .ram_wdata (seq_wdata),
        .ram_rdata (ram_rdata),
        .stat      (seq_stat)
    );

    icrmc_ram #(
        .WIDTH(8),
        .DEPTH(FRAME_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign ram_we    = (state_reg == icrmc_pkg::TP_REPAIR) ? seq_we : top_we;
    assign ram_addr  = (state_reg == icrmc_pkg::TP_REPAIR) ? seq_addr : top_addr;
    assign ram_wdata = (state_reg == icrmc_pkg::TP_REPAIR) ? seq_wdata : s_axis_tdata;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            icrmc_pkg::TP_IDLE: begin
                if (accept && s_axis_tuser) begin
                    state_next = icrmc_pkg::TP_FETCH;
                end else if (seq_start) begin
                    state_next = icrmc_pkg::TP_REPAIR;
                end
            end
            icrmc_pkg::TP_FETCH: begin
                state_next = icrmc_pkg::TP_IDLE;
            end
            icrmc_pkg::TP_REPAIR: begin
                if (seq_stat.done) begin
                    state_next = icrmc_pkg::TP_IDLE;
                end
            end
            default: begin
                state_next = icrmc_pkg::TP_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        len_next      = len_reg;
        pos_next      = pos_reg;
        too_long_next = too_long_reg;
        closed_next   = closed_reg;
        fhit_next     = fhit_reg;
        flast_next    = flast_reg;
        mv_next       = mv_reg && !m_axis_tready;
        md_next       = md_reg;
        mu_next       = mu_reg;
        ml_next       = ml_reg;
        top_we        = 1'b0;
        top_addr      = ADDR_W'(pos_reg);
        seq_start     = 1'b0;

        if (accept) begin
            if (s_axis_tuser) begin
                fhit_next  = (pos_reg < len_reg);
                flast_next = (pos_reg + POS_W'(1) == len_reg) || (pos_reg >= len_reg);
                if (pos_reg < len_reg) begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end else begin
                if (closed_reg) begin
                    pos_next = '0;
                end
                closed_next   = s_axis_tlast;
                too_long_next = (!closed_reg && too_long_reg) ||
                                (eff_len >= POS_W'(FRAME_BYTES));
                top_addr = ADDR_W'(eff_len);
                if (eff_len < POS_W'(FRAME_BYTES)) begin
                    top_we   = 1'b1;
                    len_next = eff_len + POS_W'(1);
                end else begin
                    len_next = eff_len;
                end
                if (s_axis_tlast) begin
                    if (too_long_next) begin
                        mv_next = 1'b1;
                        md_next = {3'b000, 1'b1, 4'b0000, 8'h00};
                        mu_next = 1'b0;
                        ml_next = 1'b0;
                    end else begin
                        seq_start = 1'b1;
                    end
                end
            end
        end

        if (state_reg == icrmc_pkg::TP_FETCH) begin
            mv_next = 1'b1;
            md_next = {8'h00, fhit_reg ? ram_rdata : 8'h00};
            mu_next = 1'b1;
            ml_next = flast_reg;
        end

        if (state_reg == icrmc_pkg::TP_REPAIR && seq_stat.done) begin
            mv_next = 1'b1;
            md_next = {3'b000, 1'b0, seq_stat.mss_low, seq_stat.tcp_fix,
                       seq_stat.icmp_fix, seq_stat.hdr_fix, 8'h00};
            mu_next = 1'b0;
            ml_next = 1'b0;
        end
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = md_reg;
    assign m_axis_tuser  = mu_reg;
    assign m_axis_tlast  = ml_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= icrmc_pkg::TP_IDLE;
            clamp_reg    <= 16'd0;
            len_reg      <= '0;
            pos_reg      <= '0;
            too_long_reg <= 1'b0;
            closed_reg   <= 1'b0;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_wr_en) begin
                clamp_reg <= cfg_wr_data;
            end
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            too_long_reg <= too_long_next;
            closed_reg   <= closed_next;
            mv_reg       <= mv_next;
        end
        fhit_reg  <= fhit_next;
        flast_reg <= flast_next;
        md_reg    <= md_next;
        mu_reg    <= mu_next;
        ml_reg    <= ml_next;
    end

endmodule

`default_nettype wire
